// ===== sv/atbl_pkg.sv =====
// Shared constants, codes and word types for the array table block.
package atbl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int IDX_W  = 6;
  localparam int CAP_W  = 6;
  localparam int ST_W   = 2;
  localparam int POS_W  = 5;
  localparam int FILL_W = 6;

  // Stream word widths, rounded up to whole bytes
  localparam int IN_BITS     = IDX_W + DATA_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = ST_W + DATA_W + POS_W + FILL_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
  localparam logic [OP_W-1:0] OP_LSEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_BSEARCH = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECT  = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

  // One request word
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // One result word
  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] removed_value;
    logic [POS_W-1:0]         position;
    logic [FILL_W-1:0]        fill_after;
  } res_t;

  // Compare unit outputs
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

endpackage

// ===== sv/atbl_cmp.sv =====
// Shared compare unit: equality and signed less-than of key against entry.
module atbl_cmp (
  input  logic signed [atbl_pkg::DATA_W-1:0] key,
  input  logic signed [atbl_pkg::DATA_W-1:0] entry,
  output atbl_pkg::cmp_t                     res
);

  // Compare key with the entry just read
  always_comb begin
    res.eq = (key == entry);
    res.lt = (key < entry);
  end

endmodule

// ===== sv/atbl_core.sv =====
// Sequencer, entry memory and fill count of the array table.
module atbl_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [atbl_pkg::CAP_W-1:0]  cap,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  atbl_pkg::req_t              req_in,
  output logic                        res_valid,
  input  logic                        res_ready,
  output atbl_pkg::res_t              res_out
);

  localparam int ADDR_W = atbl_pkg::ADDR_W;
  localparam int CNT_W  = atbl_pkg::CNT_W;
  localparam int DATA_W = atbl_pkg::DATA_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_SHIFT_UP = 4'd2;
  localparam logic [3:0] S_PUT      = 4'd3;
  localparam logic [3:0] S_DEL_GRAB = 4'd4;
  localparam logic [3:0] S_SHIFT_DN = 4'd5;
  localparam logic [3:0] S_LSCAN    = 4'd6;
  localparam logic [3:0] S_LSWAP    = 4'd7;
  localparam logic [3:0] S_BS_ISSUE = 4'd8;
  localparam logic [3:0] S_BS_CMP   = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]                   state, state_next;
  atbl_pkg::req_t               req;
  logic [CNT_W-1:0]             fill, fill_next;
  logic [CNT_W-1:0]             wptr, wptr_next;
  logic [CNT_W-1:0]             wptr_up1, wptr_up2, wptr_dn1, wptr_dn2;
  logic [CNT_W-1:0]             idx, room;
  logic signed [CNT_W:0]        lo, lo_next, hi, hi_next, mid_ext;
  logic signed [CNT_W+1:0]      mid_sum;
  logic [ADDR_W-1:0]            mid, mid_next;
  logic [DATA_W-1:0]            prev, prev_next;
  logic [atbl_pkg::ST_W-1:0]    status, status_next;
  logic [DATA_W-1:0]            removed, removed_next;
  logic [atbl_pkg::POS_W-1:0]   pos, pos_next;
  atbl_pkg::cmp_t               cmp;

  // Entry memory: one write and one registered read per cycle
  logic [DATA_W-1:0]            mem [atbl_pkg::TABLE_DEPTH];
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr, mem_raddr;
  logic [DATA_W-1:0]            mem_wdata, rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Key against the entry read last cycle
  atbl_cmp u_cmp (
    .key   (req.value),
    .entry (rdata),
    .res   (cmp)
  );

  // Pointer arithmetic and room left under the capacity limit
  always_comb begin
    idx      = CNT_W'(req.index);
    wptr_up1 = wptr + CNT_W'(1);
    wptr_up2 = wptr + CNT_W'(2);
    wptr_dn1 = wptr - CNT_W'(1);
    wptr_dn2 = wptr - CNT_W'(2);
    mid_sum  = (CNT_W+2)'(lo) + (CNT_W+2)'(hi);
    mid_ext  = $signed({{(CNT_W+1-ADDR_W){1'b0}}, mid});
    if (int'(cap) > atbl_pkg::TABLE_DEPTH) begin
      room = CNT_W'(atbl_pkg::TABLE_DEPTH);
    end else begin
      room = CNT_W'(cap);
    end
  end

  // Handshake toward the top level
  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res_out.status        = status;
    res_out.removed_value = removed;
    res_out.position      = pos;
    res_out.fill_after    = atbl_pkg::FILL_W'(fill);
  end

  // Sequence one request over the memory port
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    wptr_next    = wptr;
    lo_next      = lo;
    hi_next      = hi;
    mid_next     = mid;
    prev_next    = prev;
    status_next  = status;
    removed_next = removed;
    pos_next     = pos;
    mem_we       = 1'b0;
    mem_waddr    = wptr[ADDR_W-1:0];
    mem_wdata    = rdata;
    mem_raddr    = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          status_next  = atbl_pkg::ST_REJECT;
          removed_next = '0;
          pos_next     = '0;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (req.op)
          atbl_pkg::OP_APPEND: begin
            if (fill < room) begin
              mem_we      = 1'b1;
              mem_waddr   = fill[ADDR_W-1:0];
              mem_wdata   = req.value;
              fill_next   = fill + CNT_W'(1);
              status_next = atbl_pkg::ST_DONE;
            end
          end
          atbl_pkg::OP_INSERT: begin
            if (fill < room && idx <= fill) begin
              fill_next   = fill + CNT_W'(1);
              status_next = atbl_pkg::ST_DONE;
              if (idx == fill) begin
                mem_we    = 1'b1;
                mem_waddr = idx[ADDR_W-1:0];
                mem_wdata = req.value;
              end else begin
                mem_raddr  = ADDR_W'(fill - CNT_W'(1));
                wptr_next  = fill;
                state_next = S_SHIFT_UP;
              end
            end
          end
          atbl_pkg::OP_DELETE: begin
            if (idx < fill) begin
              mem_raddr  = idx[ADDR_W-1:0];
              state_next = S_DEL_GRAB;
            end
          end
          atbl_pkg::OP_LSEARCH: begin
            status_next = atbl_pkg::ST_MISSING;
            if (fill != '0) begin
              mem_raddr  = '0;
              wptr_next  = '0;
              state_next = S_LSCAN;
            end
          end
          atbl_pkg::OP_BSEARCH: begin
            status_next = atbl_pkg::ST_MISSING;
            lo_next     = '0;
            hi_next     = $signed({1'b0, fill}) - (CNT_W+1)'(1);
            state_next  = S_BS_ISSUE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      // Move one entry up per cycle, from the top down to the index
      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = wptr[ADDR_W-1:0];
        mem_wdata = rdata;
        mem_raddr = wptr_dn2[ADDR_W-1:0];
        wptr_next = wptr_dn1;
        if (wptr_dn1 == idx) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[ADDR_W-1:0];
        mem_wdata  = req.value;
        state_next = S_DONE;
      end
      // Take the removed entry, then close the gap
      S_DEL_GRAB: begin
        removed_next = rdata;
        status_next  = atbl_pkg::ST_DONE;
        fill_next    = fill - CNT_W'(1);
        if (idx + CNT_W'(1) < fill) begin
          mem_raddr  = ADDR_W'(idx + CNT_W'(1));
          wptr_next  = idx;
          state_next = S_SHIFT_DN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = wptr[ADDR_W-1:0];
        mem_wdata = rdata;
        if (wptr_up1 < fill) begin
          mem_raddr = wptr_up2[ADDR_W-1:0];
          wptr_next = wptr_up1;
        end else begin
          state_next = S_DONE;
        end
      end
      // Scan from the front, one entry per cycle
      S_LSCAN: begin
        if (cmp.eq) begin
          status_next = atbl_pkg::ST_DONE;
          if (wptr == '0) begin
            pos_next   = '0;
            state_next = S_DONE;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = wptr_dn1[ADDR_W-1:0];
            mem_wdata  = rdata;
            pos_next   = wptr_dn1[atbl_pkg::POS_W-1:0];
            state_next = S_LSWAP;
          end
        end else begin
          prev_next = rdata;
          if (wptr_up1 < fill) begin
            mem_raddr = wptr_up1[ADDR_W-1:0];
            wptr_next = wptr_up1;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_LSWAP: begin
        mem_we     = 1'b1;
        mem_waddr  = wptr[ADDR_W-1:0];
        mem_wdata  = prev;
        state_next = S_DONE;
      end
      // Halve the window: read the middle, then compare
      S_BS_ISSUE: begin
        if (lo <= hi) begin
          mid_next   = mid_sum[ADDR_W:1];
          mem_raddr  = mid_sum[ADDR_W:1];
          state_next = S_BS_CMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BS_CMP: begin
        if (cmp.eq) begin
          status_next = atbl_pkg::ST_DONE;
          pos_next    = atbl_pkg::POS_W'(mid);
          state_next  = S_DONE;
        end else begin
          if (cmp.lt) begin
            hi_next = mid_ext - (CNT_W+1)'(1);
          end else begin
            lo_next = mid_ext + (CNT_W+1)'(1);
          end
          state_next = S_BS_ISSUE;
        end
      end
      // Hold the result until the output stage takes it
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req <= req_in;
    end
    wptr    <= wptr_next;
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= mid_next;
    prev    <= prev_next;
    status  <= status_next;
    removed <= removed_next;
    pos     <= pos_next;
  end

endmodule

// ===== sv/array_table_insert_delete_search.sv =====
// Top level of the array table: stream ports, capacity register, output stage.
//
// A packed table of up to 32 signed 32-bit entries. Each request word on the
// s_ channel carries an operation in s_tuser (append, insert, delete, linear
// search with transposition, binary search) and an index and value in
// s_tdata. Every request yields one result word on the m_ channel with the
// status, the removed entry, the found position and the fill count.
// cfg_we/cfg_wdata set the capacity limit; write it only while idle.
// Insert inside the table shifts the entries from the top down to the index up
// one at a time, then writes the value; delete reads the removed entry, then
// shifts the entries above it down; linear search scans from the front and
// swaps a hit with the entry before it; binary search reads the middle entry
// and compares it with the key for each halving step of the window.
// All table work goes through one memory port and one compare unit, so one
// request is in flight at a time; s_tready is high while the sequencer idles.
// A finished result sits in the output register and the next request is taken
// while it waits; a stalled m_tready holds the following result in the core.
// Reset empties the table (fill count zero) and sets the capacity to 32;
// entry contents are not cleared and need no clearing pass.
module array_table_insert_delete_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [atbl_pkg::CAP_W-1:0]          cfg_wdata,    // capacity_limit
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [atbl_pkg::IN_TDATA_W-1:0]     s_tdata,      // index, value
  input  logic [atbl_pkg::OP_W-1:0]           s_tuser,      // op
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [atbl_pkg::OUT_TDATA_W-1:0]    m_tdata       // status, removed_value,
                                                            // position, fill_after
);

  logic [atbl_pkg::CAP_W-1:0] cap;
  atbl_pkg::req_t             req;
  atbl_pkg::res_t             res;
  logic                       res_valid, res_ready;

  // Hold the capacity limit
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= atbl_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  // Unpack the request word
  always_comb begin
    req.op    = s_tuser;
    req.index = s_tdata[atbl_pkg::IDX_W-1:0];
    req.value = s_tdata[atbl_pkg::IN_BITS-1:atbl_pkg::IDX_W];
  end

  atbl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_in    (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_out   (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {{(atbl_pkg::OUT_TDATA_W - atbl_pkg::OUT_BITS){1'b0}},
                  res.fill_after, res.position, res.removed_value, res.status};
    end
  end

endmodule
